// ----- hdl/spae_pkg.sv -----
// Package for the sparse polynomial accumulate and evaluate block.
// Holds table sizes, transaction payload structs, the controller state and
// datapath command enums, and the datapath status struct. No dependencies.
package spae_pkg;

   localparam int MAX_TERMS = 16;
   localparam int EXPO_BITS = 8;
   localparam int COEF_W    = 32;
   localparam int EXPO_IN_W = 8;
   localparam int ADDR_W    = $clog2(MAX_TERMS);
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);

   typedef struct packed {
      logic                     action;
      logic signed [COEF_W-1:0] term_coef;
      logic [EXPO_IN_W-1:0]     term_expo;
      logic signed [COEF_W-1:0] x_value;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] poly_value;
      logic [CNT_W-1:0]         term_count;
      logic                     status;
   } rsp_type;

   typedef struct packed {
      logic [EXPO_BITS-1:0] expo;
      logic [COEF_W-1:0]    coef;
   } entry_type;

   localparam logic ACTION_ADD  = 1'b0;
   localparam logic ACTION_EVAL = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DEL_DONE,
      ST_INS_MARK,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_EVAL_RD,
      ST_EVAL_LOAD,
      ST_EVAL_POW,
      ST_RSP_OK,
      ST_RSP_FULL,
      ST_RSP_EVAL
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_READ,
      OP_SCAN_NEXT,
      OP_MERGE_WR,
      OP_DEL_RD,
      OP_DEL_WR,
      OP_CNT_DEC,
      OP_MARK,
      OP_INS_RD,
      OP_INS_WR,
      OP_INS_PUT,
      OP_POW_LOAD,
      OP_POW_STEP,
      OP_MAC,
      OP_RSP_OK,
      OP_RSP_FULL,
      OP_RSP_EVAL
   } dp_op_type;

   typedef struct packed {
      logic is_eval;
      logic coef_zero;
      logic idx_at_cnt;
      logic idx_at_pos;
      logic idx_last;
      logic full;
      logic expo_gt;
      logic expo_eq;
      logic sum_zero;
      logic pow_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- hdl/spae_dp.sv -----
// Datapath of the sparse polynomial block: term memory, index counters,
// power and multiply-accumulate unit, and the result register.
// Depends on spae_pkg; driven by commands from spae_ctrl.
module spae_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  spae_pkg::dp_op_type     op,
   input  spae_pkg::req_type       req_data,
   output spae_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output spae_pkg::rsp_type       rsp_data
);

   spae_pkg::entry_type mem [spae_pkg::MAX_TERMS];

   spae_pkg::req_type   req_ff;
   spae_pkg::entry_type rd_ff;
   spae_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   logic [spae_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [spae_pkg::CNT_W-1:0] idx_ff;
   logic [spae_pkg::CNT_W-1:0] pos_ff;
   logic [spae_pkg::CNT_W-1:0] idx_plus1;
   logic [spae_pkg::CNT_W-1:0] idx_minus1;

   logic [spae_pkg::COEF_W-1:0]    pow_r_ff;
   logic [spae_pkg::COEF_W-1:0]    pow_b_ff;
   logic [spae_pkg::EXPO_BITS-1:0] pow_e_ff;
   logic [spae_pkg::COEF_W-1:0]    acc_ff;
   logic [spae_pkg::COEF_W-1:0]    r_mul;
   logic [spae_pkg::COEF_W-1:0]    b_sq;
   logic [spae_pkg::COEF_W-1:0]    term_prod;

   logic [spae_pkg::EXPO_BITS-1:0] expo_in;
   logic [spae_pkg::COEF_W-1:0]    coef_in;
   logic [spae_pkg::COEF_W-1:0]    sum;

   logic                       mem_we;
   logic                       mem_re;
   logic [spae_pkg::ADDR_W-1:0] mem_waddr;
   logic [spae_pkg::ADDR_W-1:0] mem_raddr;
   spae_pkg::entry_type        mem_wdata;
   logic                       rsp_load;

   assign expo_in    = req_ff.term_expo[spae_pkg::EXPO_BITS-1:0];
   assign coef_in    = req_ff.term_coef;
   assign sum        = rd_ff.coef + coef_in;
   assign idx_plus1  = idx_ff + 1'b1;
   assign idx_minus1 = idx_ff - 1'b1;
   assign r_mul      = pow_r_ff * pow_b_ff;
   assign b_sq       = pow_b_ff * pow_b_ff;
   assign term_prod  = rd_ff.coef * pow_r_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = idx_ff[spae_pkg::ADDR_W-1:0];
      mem_raddr = idx_ff[spae_pkg::ADDR_W-1:0];
      mem_wdata = rd_ff;
      case (op)
         spae_pkg::OP_READ: begin
            mem_re = 1'b1;
         end
         spae_pkg::OP_DEL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = idx_plus1[spae_pkg::ADDR_W-1:0];
         end
         spae_pkg::OP_INS_RD: begin
            mem_re    = 1'b1;
            mem_raddr = idx_minus1[spae_pkg::ADDR_W-1:0];
         end
         spae_pkg::OP_MERGE_WR: begin
            mem_we         = 1'b1;
            mem_wdata.expo = expo_in;
            mem_wdata.coef = sum;
         end
         spae_pkg::OP_DEL_WR, spae_pkg::OP_INS_WR: begin
            mem_we = 1'b1;
         end
         spae_pkg::OP_INS_PUT: begin
            mem_we         = 1'b1;
            mem_wdata.expo = expo_in;
            mem_wdata.coef = coef_in;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   assign rsp_load = (op == spae_pkg::OP_RSP_OK) || (op == spae_pkg::OP_RSP_FULL) ||
                     (op == spae_pkg::OP_RSP_EVAL);

   always_comb begin
      cnt_in = cnt_ff;
      if (op == spae_pkg::OP_INS_PUT) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (op == spae_pkg::OP_CNT_DEC) begin
         cnt_in = cnt_ff - 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         spae_pkg::OP_CAPTURE: begin
            req_ff <= req_data;
            idx_ff <= '0;
            acc_ff <= '0;
         end
         spae_pkg::OP_SCAN_NEXT, spae_pkg::OP_DEL_WR: begin
            idx_ff <= idx_plus1;
         end
         spae_pkg::OP_INS_WR: begin
            idx_ff <= idx_minus1;
         end
         spae_pkg::OP_MARK: begin
            pos_ff <= idx_ff;
            idx_ff <= cnt_ff;
         end
         spae_pkg::OP_POW_LOAD: begin
            pow_r_ff <= 32'd1;
            pow_b_ff <= req_ff.x_value;
            pow_e_ff <= rd_ff.expo;
         end
         spae_pkg::OP_POW_STEP: begin
            if (pow_e_ff[0]) begin
               pow_r_ff <= r_mul;
            end
            pow_b_ff <= b_sq;
            pow_e_ff <= pow_e_ff >> 1;
         end
         spae_pkg::OP_MAC: begin
            acc_ff <= acc_ff + term_prod;
            idx_ff <= idx_plus1;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_ff.term_count <= cnt_ff;
         rsp_ff.poly_value <= (op == spae_pkg::OP_RSP_EVAL) ? $signed(acc_ff) : '0;
         rsp_ff.status     <= (op == spae_pkg::OP_RSP_FULL);
      end
   end

   always_comb begin
      status.is_eval    = (req_ff.action == spae_pkg::ACTION_EVAL);
      status.coef_zero  = (coef_in == '0);
      status.idx_at_cnt = (idx_ff == cnt_ff);
      status.idx_at_pos = (idx_ff == pos_ff);
      status.idx_last   = (idx_plus1 >= cnt_ff);
      status.full       = (cnt_ff == spae_pkg::CNT_W'(spae_pkg::MAX_TERMS));
      status.expo_gt    = (rd_ff.expo > expo_in);
      status.expo_eq    = (rd_ff.expo == expo_in);
      status.sum_zero   = (sum == '0);
      status.pow_done   = (pow_e_ff == '0);
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= spae_pkg::CNT_W'(spae_pkg::MAX_TERMS))
      else $error("Term count exceeds table depth.");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      op == spae_pkg::OP_INS_PUT |-> cnt_ff < spae_pkg::CNT_W'(spae_pkg::MAX_TERMS))
      else $error("Insert issued into a full table.");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      op == spae_pkg::OP_INS_RD |-> idx_ff != '0 && idx_ff != pos_ff)
      else $error("Insert shift read outside the moved range.");

   a_rsp_set: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("Result register not marked valid after load.");

endmodule

// ----- hdl/spae_ctrl.sv -----
// Controller state machine of the sparse polynomial block.
// Depends on spae_pkg; sequences spae_dp through command and status signals.
module spae_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  spae_pkg::dp_status_type status,
   output spae_pkg::dp_op_type     op
);

   spae_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spae_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op       = spae_pkg::OP_NONE;
      case (state_ff)
         spae_pkg::ST_IDLE: begin
            if (req_valid) begin
               op       = spae_pkg::OP_CAPTURE;
               state_in = spae_pkg::ST_DISPATCH;
            end
         end
         spae_pkg::ST_DISPATCH: begin
            if (status.is_eval) begin
               state_in = spae_pkg::ST_EVAL_RD;
            end else if (status.coef_zero) begin
               state_in = spae_pkg::ST_RSP_OK;
            end else begin
               state_in = spae_pkg::ST_SCAN_RD;
            end
         end
         spae_pkg::ST_SCAN_RD: begin
            if (status.idx_at_cnt) begin
               state_in = spae_pkg::ST_INS_MARK;
            end else begin
               op       = spae_pkg::OP_READ;
               state_in = spae_pkg::ST_SCAN_CMP;
            end
         end
         spae_pkg::ST_SCAN_CMP: begin
            if (status.expo_gt) begin
               op       = spae_pkg::OP_SCAN_NEXT;
               state_in = spae_pkg::ST_SCAN_RD;
            end else if (status.expo_eq && status.sum_zero) begin
               state_in = spae_pkg::ST_DEL_RD;
            end else if (status.expo_eq) begin
               op       = spae_pkg::OP_MERGE_WR;
               state_in = spae_pkg::ST_RSP_OK;
            end else begin
               state_in = spae_pkg::ST_INS_MARK;
            end
         end
         spae_pkg::ST_DEL_RD: begin
            if (status.idx_last) begin
               state_in = spae_pkg::ST_DEL_DONE;
            end else begin
               op       = spae_pkg::OP_DEL_RD;
               state_in = spae_pkg::ST_DEL_WR;
            end
         end
         spae_pkg::ST_DEL_WR: begin
            op       = spae_pkg::OP_DEL_WR;
            state_in = spae_pkg::ST_DEL_RD;
         end
         spae_pkg::ST_DEL_DONE: begin
            op       = spae_pkg::OP_CNT_DEC;
            state_in = spae_pkg::ST_RSP_OK;
         end
         spae_pkg::ST_INS_MARK: begin
            if (status.full) begin
               state_in = spae_pkg::ST_RSP_FULL;
            end else begin
               op       = spae_pkg::OP_MARK;
               state_in = spae_pkg::ST_INS_RD;
            end
         end
         spae_pkg::ST_INS_RD: begin
            if (status.idx_at_pos) begin
               state_in = spae_pkg::ST_INS_PUT;
            end else begin
               op       = spae_pkg::OP_INS_RD;
               state_in = spae_pkg::ST_INS_WR;
            end
         end
         spae_pkg::ST_INS_WR: begin
            op       = spae_pkg::OP_INS_WR;
            state_in = spae_pkg::ST_INS_RD;
         end
         spae_pkg::ST_INS_PUT: begin
            op       = spae_pkg::OP_INS_PUT;
            state_in = spae_pkg::ST_RSP_OK;
         end
         spae_pkg::ST_EVAL_RD: begin
            if (status.idx_at_cnt) begin
               state_in = spae_pkg::ST_RSP_EVAL;
            end else begin
               op       = spae_pkg::OP_READ;
               state_in = spae_pkg::ST_EVAL_LOAD;
            end
         end
         spae_pkg::ST_EVAL_LOAD: begin
            op       = spae_pkg::OP_POW_LOAD;
            state_in = spae_pkg::ST_EVAL_POW;
         end
         spae_pkg::ST_EVAL_POW: begin
            if (status.pow_done) begin
               op       = spae_pkg::OP_MAC;
               state_in = spae_pkg::ST_EVAL_RD;
            end else begin
               op = spae_pkg::OP_POW_STEP;
            end
         end
         spae_pkg::ST_RSP_OK: begin
            if (status.rsp_free) begin
               op       = spae_pkg::OP_RSP_OK;
               state_in = spae_pkg::ST_IDLE;
            end
         end
         spae_pkg::ST_RSP_FULL: begin
            if (status.rsp_free) begin
               op       = spae_pkg::OP_RSP_FULL;
               state_in = spae_pkg::ST_IDLE;
            end
         end
         spae_pkg::ST_RSP_EVAL: begin
            if (status.rsp_free) begin
               op       = spae_pkg::OP_RSP_EVAL;
               state_in = spae_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spae_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != spae_pkg::ST_IDLE);

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == spae_pkg::ST_DISPATCH)
      else $error("Accepted transaction was not dispatched.");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      (op == spae_pkg::OP_RSP_OK || op == spae_pkg::OP_RSP_FULL ||
       op == spae_pkg::OP_RSP_EVAL) |-> status.rsp_free)
      else $error("Result loaded while the output register is occupied.");

   a_full_no_insert: assert property (@(posedge clock) disable iff (reset)
      state_ff == spae_pkg::ST_INS_PUT |-> !status.full)
      else $error("Insert reached on a full table.");

endmodule

// ----- hdl/sparse_polynomial_accumulate_eval.sv -----
// Top level of the sparse polynomial accumulate and evaluate block.
// Depends on spae_pkg, spae_ctrl and spae_dp.
//
// The block holds one polynomial of up to 16 terms, sorted by falling exponent, in a
// term memory with a registered read. One transaction is processed at a time; a finished
// result waits in an output register while the next request is taken. A zero coefficient
// goes straight to the response. Any other add first scans the table term by term ahead
// of the target, then merges into an equal exponent, deletes a term whose sum is zero by
// moving later terms up, or inserts a new term by moving any later terms down; a full
// table answers with the full status. An evaluate reads each held term and runs one
// square-and-multiply step per bit of its exponent up to the highest set bit before it
// accumulates the term. A result is loaded once the output register is free, and the next
// transaction can be taken in the cycle after the result is loaded. Results for adds
// report a value of zero.
module sparse_polynomial_accumulate_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spae_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spae_pkg::rsp_type rsp_data
);

   spae_pkg::dp_op_type     op;
   spae_pkg::dp_status_type status;

   spae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   spae_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
